@@ src/bmtp_pkg.sv @@
// Shared types, constants and helpers for the BLE-MIDI transmit packetizer.
package bmtp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TsW   = 13;

  localparam logic [ByteW-1:0] EndOfSysex = 8'hF7;
  localparam logic [ByteW-1:0] PktMsbSet  = 8'h80;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_APPEND,
    ST_TEST,
    ST_HDR,
    ST_TS,
    ST_DATA
  } state_e;

  // Which byte the output mux presents
  typedef enum logic [1:0] {
    OUT_HDR,
    OUT_TS,
    OUT_DATA
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;      // capture the incoming item
    logic     append;    // write held byte at fill position
    logic     flush;     // packet done: clear fill count and first entry
    logic     idx_clr;   // restart data byte index
    logic     idx_inc;   // advance data byte index
    out_sel_e out_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_eox;     // held byte is end of sysex
    logic fill_zero;  // nothing pending
    logic msg_done;   // fixed-length message complete or buffer full
    logic with_ts;    // first buffered byte is a status byte
    logic data_last;  // current data byte is the final one
  } sts_t;

  // Message length implied by a leading byte, 0 when it has none
  function automatic logic [1:0] lead_len(input logic [ByteW-1:0] s);
    logic [1:0] len;
    len = 2'd0;
    if (s >= 8'hF4 || s == 8'hF1) begin
      len = 2'd1;
    end else if ((s >= 8'hC0 && s <= 8'hDF) || s == 8'hF3) begin
      len = 2'd2;
    end else if ((s >= 8'h80 && s <= 8'hBF) || (s >= 8'hE0 && s <= 8'hEF) ||
                 s == 8'hF2) begin
      len = 2'd3;
    end
    return len;
  endfunction

endpackage

@@ src/ble_midi_tx_packetizer_unit.sv @@
// BLE-MIDI transmit packetizer: buffers MIDI bytes and emits packet bytes.
// One item at a time. An item that completes no packet goes through accept,
// check, append and length test. A packet follows the length test with one byte
// per cycle while ready: header, timestamp byte when led by a status byte, data.
// An end of sysex with bytes pending emits two packets for one item.
// Reset clears the fill count and the controller; buffer contents are don't-care.
module ble_midi_tx_packetizer_unit import bmtp_pkg::*; #(
  parameter int unsigned TX_BUFFER_BYTES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] midi_byte, [20:8] timestamp_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] packet_byte
  output logic        m_axis_tlast   // last_of_packet
);

  cmd_t cmd;
  sts_t sts;

  bmtp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_last_o  (m_axis_tlast)
  );

  bmtp_datapath #(
    .TX_BUFFER_BYTES(TX_BUFFER_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .midi_byte_i    (s_axis_tdata[7:0]),
    .timestamp_ms_i (s_axis_tdata[20:8]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .packet_byte_o  (m_axis_tdata)
  );

  // No input taken while packet bytes are going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while emitting");

  // An accepted item is evaluated before any output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("output right after accept");

  // A packet ends with an empty buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> sts.fill_zero)
    else $error("fill count not cleared after packet");

  // Header byte never closes a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cmd.out_sel == OUT_HDR) |-> !m_axis_tlast)
    else $error("header marked last");

endmodule

@@ src/bmtp_datapath.sv @@
// Datapath: held item, message buffer, fill count, byte index and output mux.
module bmtp_datapath import bmtp_pkg::*; #(
  parameter int unsigned TX_BUFFER_BYTES = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] midi_byte_i,
  input  logic [TsW-1:0]   timestamp_ms_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [ByteW-1:0] packet_byte_o
);

  localparam int unsigned IdxW  = $clog2(TX_BUFFER_BYTES);
  localparam int unsigned FillW = $clog2(TX_BUFFER_BYTES + 1);

  logic [ByteW-1:0] byte_q;
  logic [TsW-1:0]   ts_q;
  logic [ByteW-1:0] buf_q [TX_BUFFER_BYTES];
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [1:0]       len;

  // Held item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= midi_byte_i;
      ts_q   <= timestamp_ms_i;
    end
  end

  // Buffer entries; the first is cleared after each packet
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      buf_q[fill_q[IdxW-1:0]] <= byte_q;
    end else if (cmd_i.flush) begin
      buf_q[0] <= '0;
    end
  end

  // Fill count and data index
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.flush) begin
      fill_d = '0;
    end else if (cmd_i.append) begin
      fill_d = fill_q + FillW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
    end
  end

  // Status toward the controller
  assign len               = lead_len(buf_q[0]);
  assign sts_o.is_eox      = (byte_q == EndOfSysex);
  assign sts_o.fill_zero   = (fill_q == '0);
  assign sts_o.msg_done    = ((len != 2'd0) && (fill_q == FillW'(len))) ||
                             (fill_q == FillW'(TX_BUFFER_BYTES));
  assign sts_o.with_ts     = buf_q[0][ByteW-1];
  assign sts_o.data_last   = ((FillW'(idx_q) + FillW'(1)) == fill_q);

  // Output byte: header, timestamp byte or buffered data
  always_comb begin
    unique case (cmd_i.out_sel)
      OUT_HDR:  packet_byte_o = PktMsbSet | ByteW'(ts_q[TsW-1:7]);
      OUT_TS:   packet_byte_o = PktMsbSet | ByteW'(ts_q[6:0]);
      OUT_DATA: packet_byte_o = buf_q[idx_q];
      default:  packet_byte_o = '0;
    endcase
  end

endmodule

@@ src/bmtp_ctrl.sv @@
// Controller: sequences buffering, length test and packet byte emission.
module bmtp_ctrl import bmtp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic s_ready_o,
  output logic m_valid_o,
  output logic m_last_o
);

  state_e state_q, state_d;
  logic   reappend_q, reappend_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = (sts_i.is_eox && !sts_i.fill_zero) ? ST_HDR : ST_APPEND;
      ST_APPEND: state_d = ST_TEST;
      ST_TEST:   state_d = sts_i.msg_done ? ST_HDR : ST_IDLE;
      ST_HDR:    if (m_ready_i) state_d = sts_i.with_ts ? ST_TS : ST_DATA;
      ST_TS:     if (m_ready_i) state_d = ST_DATA;
      ST_DATA: begin
        if (m_ready_i && sts_i.data_last) begin
          state_d = reappend_q ? ST_APPEND : ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Pending end-of-sysex still to be buffered after its pre-flush
  always_comb begin
    reappend_d = reappend_q;
    if (state_q == ST_CHECK) begin
      reappend_d = sts_i.is_eox && !sts_i.fill_zero;
    end else if (state_q == ST_APPEND) begin
      reappend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      reappend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      reappend_q <= reappend_d;
    end
  end

  // Outputs
  always_comb begin
    cmd_o     = '{load: 1'b0, append: 1'b0, flush: 1'b0, idx_clr: 1'b0,
                  idx_inc: 1'b0, out_sel: OUT_HDR};
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    m_last_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_CHECK:  ;
      ST_APPEND: cmd_o.append = 1'b1;
      ST_TEST:   ;
      ST_HDR: begin
        m_valid_o     = 1'b1;
        cmd_o.idx_clr = 1'b1;
        cmd_o.out_sel = OUT_HDR;
      end
      ST_TS: begin
        m_valid_o     = 1'b1;
        cmd_o.out_sel = OUT_TS;
      end
      ST_DATA: begin
        m_valid_o     = 1'b1;
        m_last_o      = sts_i.data_last;
        cmd_o.out_sel = OUT_DATA;
        cmd_o.idx_inc = m_ready_i;
        cmd_o.flush   = m_ready_i && sts_i.data_last;
      end
      default: ;
    endcase
  end

endmodule

@@ test/ble_midi_tx_packetizer_unit_test.sv @@
// Self-checking testbench for the BLE-MIDI transmit packetizer.
module ble_midi_tx_packetizer_unit_test;
  import bmtp_pkg::*;

  localparam int unsigned BufBytes     = 3;
  localparam int unsigned RandomItems  = 75;
  localparam int unsigned CalmItems    = 20;
  localparam int unsigned WatchLimit   = 1000;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned DirectedRows = 25;

  // Leading-byte classes
  localparam logic [7:0] ChanThreeLo = 8'h80;
  localparam logic [7:0] ChanThreeHi = 8'hBF;
  localparam logic [7:0] ChanTwoLo   = 8'hC0;
  localparam logic [7:0] ChanTwoHi   = 8'hDF;
  localparam logic [7:0] PitchLo     = 8'hE0;
  localparam logic [7:0] PitchHi     = 8'hEF;
  localparam logic [7:0] SysexStart  = 8'hF0;
  localparam logic [7:0] TimeCode    = 8'hF1;
  localparam logic [7:0] SongPos     = 8'hF2;
  localparam logic [7:0] SongSel     = 8'hF3;
  localparam logic [7:0] RealTimeLo  = 8'hF4;
  localparam logic [7:0] ByteMax     = 8'hFF;
  localparam logic [7:0] DataMax     = 8'h7F;
  localparam logic [7:0] TimingClock = 8'hF8;

  typedef enum {
    MSG_CHAN3, MSG_CHAN2, MSG_SYSCOMMON, MSG_REALTIME, MSG_SYSEX, MSG_NOISE, MSG_BROKEN
  } msg_kind_e;

  // One packet byte as it leaves the block
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } pkt_beat_t;

  // Directed row; typed beats listed first-out in the top slot
  typedef struct packed {
    logic [7:0]       midi;
    logic [12:0]      ts;
    logic             typed;
    logic [1:0]       n_typed;
    logic [2:0][8:0]  beats;
  } stim_row_t;

  localparam stim_row_t DirectedTable [DirectedRows] = '{
    // after reset: one-byte real-time message at time zero
    '{8'hF8, 13'd0,    1'b1, 2'd3, {9'h080, 9'h080, 9'h1F8}},
    // all-ones byte and timestamp
    '{8'hFF, 13'h1FFF, 1'b1, 2'd3, {9'h0BF, 9'h0FF, 9'h1FF}},
    // data byte with no leading status: gathers, nothing out
    '{8'h00, 13'd0,    1'b1, 2'd0, 27'd0},
    '{8'h7F, 13'd1234, 1'b0, 2'd0, 27'd0},
    '{8'h55, 13'd4095, 1'b0, 2'd0, 27'd0},  // full buffer leaves as a fragment
    '{8'h90, 13'd127,  1'b0, 2'd0, 27'd0},
    '{8'h3C, 13'd128,  1'b0, 2'd0, 27'd0},
    '{8'h7F, 13'd129,  1'b0, 2'd0, 27'd0},
    '{8'hC0, 13'd300,  1'b0, 2'd0, 27'd0},
    '{8'h05, 13'd301,  1'b0, 2'd0, 27'd0},
    '{8'hF3, 13'd5000, 1'b0, 2'd0, 27'd0},
    '{8'h01, 13'd5001, 1'b0, 2'd0, 27'd0},
    '{8'hF2, 13'd6000, 1'b0, 2'd0, 27'd0},
    '{8'h10, 13'd6001, 1'b0, 2'd0, 27'd0},
    '{8'h20, 13'd6002, 1'b0, 2'd0, 27'd0},
    // sysex with pending bytes, then end of sysex: two packets in one item
    '{8'hF0, 13'd7000, 1'b0, 2'd0, 27'd0},
    '{8'h01, 13'd7001, 1'b0, 2'd0, 27'd0},
    '{8'hF7, 13'd7002, 1'b0, 2'd0, 27'd0},
    '{8'hF7, 13'd8190, 1'b0, 2'd0, 27'd0},  // end of sysex with nothing pending
    // real-time byte lands inside a gathering message
    '{8'hE0, 13'd2000, 1'b0, 2'd0, 27'd0},
    '{8'hF8, 13'd2001, 1'b0, 2'd0, 27'd0},
    '{8'h40, 13'd2002, 1'b0, 2'd0, 27'd0},
    '{8'hF1, 13'd3333, 1'b0, 2'd0, 27'd0},
    // data-led flush by end of sysex: no timestamp byte
    '{8'h12, 13'd777,  1'b0, 2'd0, 27'd0},
    '{8'hF7, 13'd778,  1'b0, 2'd0, 27'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] midi_byte, [20:8] timestamp_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // [7:0] packet_byte
  logic        m_axis_tlast;   // last_of_packet

  // Predictor state
  logic [7:0]  pend_bytes [BufBytes];
  int unsigned pend_count;
  pkt_beat_t   step_beats [$];
  pkt_beat_t   expected_beats [$];

  int unsigned fail_count;
  int unsigned random_items;
  int unsigned idle_cycles;
  int unsigned rx_stall_left;
  int unsigned rx_quiet_left;
  bit          tx_quiet;
  bit          calm_tail;

  ble_midi_tx_packetizer_unit #(
    .TX_BUFFER_BYTES(BufBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Message length fixed by a leading byte, 0 when open-ended
  function automatic int unsigned fixed_len(input logic [7:0] s);
    if (s >= RealTimeLo || s == TimeCode) return 1;
    if ((s >= ChanTwoLo && s <= ChanTwoHi) || s == SongSel) return 2;
    if ((s >= ChanThreeLo && s <= ChanThreeHi) || (s >= PitchLo && s <= PitchHi) ||
        s == SongPos) return 3;
    return 0;
  endfunction

  // Turn pending bytes into one packet
  function automatic void flush_pending(input logic [12:0] ts);
    int unsigned i;
    pkt_beat_t   beat;
    beat.last = 1'b0;
    beat.data = {2'b10, ts[12:7]};
    step_beats.push_back(beat);
    if (pend_bytes[0][7]) begin
      beat.data = {1'b1, ts[6:0]};
      step_beats.push_back(beat);
    end
    for (i = 0; i < pend_count; i++) begin
      beat.data = pend_bytes[i];
      step_beats.push_back(beat);
    end
    step_beats[step_beats.size()-1].last = 1'b1;
    pend_bytes[0] = 8'h00;
    pend_count = 0;
  endfunction

  // Packet bytes caused by one MIDI byte
  function automatic void encode_midi_byte(input logic [7:0] b, input logic [12:0] ts);
    step_beats.delete();
    if (pend_count >= BufBytes) pend_count = 0;
    if (b == EndOfSysex && pend_count > 0) flush_pending(ts);
    pend_bytes[pend_count] = b;
    pend_count++;
    if (fixed_len(pend_bytes[0]) == pend_count) begin
      flush_pending(ts);
    end else if (pend_count == BufBytes) begin
      flush_pending(ts);
    end
  endfunction

  // Offer one item; returns at the falling edge after it is taken
  task automatic send_item(input logic [7:0] b, input logic [12:0] ts, input logic typed,
                           input int unsigned n_typed, input logic [2:0][8:0] beats);
    int unsigned gap;
    int unsigned j;
    if (!calm_tail && !tx_quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ts, b};
    do @(posedge clk_i); while (!s_axis_tready);
    encode_midi_byte(b, ts);
    if (typed) begin
      for (j = 0; j < n_typed; j++) expected_beats.push_back(pkt_beat_t'(beats[2-j]));
    end else begin
      for (j = 0; j < step_beats.size(); j++) expected_beats.push_back(step_beats[j]);
    end
    @(negedge clk_i);
  endtask

  task automatic send_random(input logic [7:0] b);
    send_item(b, 13'($urandom_range(0, 8191)), 1'b0, 0, '0);
    random_items++;
  endtask

  // Sender holds off until every expected byte is out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One MIDI message, mostly well formed, with random content
  task automatic send_message();
    msg_kind_e   kind;
    int unsigned n;
    int unsigned k;
    tx_quiet = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0, 1:    kind = MSG_CHAN3;
      2, 3:    kind = MSG_CHAN2;
      4:       kind = MSG_SYSCOMMON;
      5:       kind = MSG_REALTIME;
      6, 7:    kind = MSG_SYSEX;
      8:       kind = MSG_NOISE;
      default: kind = MSG_BROKEN;
    endcase
    case (kind)
      MSG_CHAN3: begin
        if ($urandom_range(0, 1)) send_random(ChanThreeLo | 8'($urandom_range(0, 63)));
        else send_random(PitchLo | 8'($urandom_range(0, 15)));
        send_random(8'($urandom_range(0, DataMax)));
        send_random(8'($urandom_range(0, DataMax)));
      end
      MSG_CHAN2: begin
        send_random(ChanTwoLo | 8'($urandom_range(0, 31)));
        send_random(8'($urandom_range(0, DataMax)));
      end
      MSG_SYSCOMMON: begin
        case ($urandom_range(0, 2))
          0: send_random(TimeCode);
          1: begin
            send_random(SongPos);
            send_random(8'($urandom_range(0, DataMax)));
            send_random(8'($urandom_range(0, DataMax)));
          end
          default: begin
            send_random(SongSel);
            send_random(8'($urandom_range(0, DataMax)));
          end
        endcase
      end
      MSG_REALTIME: send_random(8'($urandom_range(RealTimeLo, ByteMax)));
      MSG_SYSEX: begin
        send_random(SysexStart);
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 7) == 0) send_random(TimingClock);
          else send_random(8'($urandom_range(0, DataMax)));
        end
        send_random(EndOfSysex);
      end
      MSG_NOISE: begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_random(8'($urandom_range(0, ByteMax)));
      end
      default: begin
        // truncated three-byte message; whatever follows lands in its buffer
        send_random(ChanThreeLo | 8'($urandom_range(0, 63)));
        send_random(8'($urandom_range(0, DataMax)));
      end
    endcase
  endtask

  // Receiver readiness: stall bursts, quiet stretches, none at the tail
  always @(negedge clk_i) begin
    if (!rst_ni || calm_tail) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else if (rx_quiet_left > 0) begin
      m_axis_tready <= 1'b1;
      rx_quiet_left = rx_quiet_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          m_axis_tready <= 1'b0;
          rx_stall_left = $urandom_range(0, 7);
        end
        9: begin
          m_axis_tready <= 1'b1;
          rx_quiet_left = $urandom_range(20, 60);
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Output check against the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin : check_beat
      pkt_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("packet_byte: no item expected, got %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("packet_byte: expected %h, got %h", want.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_packet: expected %b, got %b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    int unsigned r;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    fail_count    = 0;
    random_items  = 0;
    idle_cycles   = 0;
    rx_stall_left = 0;
    rx_quiet_left = 0;
    tx_quiet      = 1'b0;
    calm_tail     = 1'b0;
    pend_count    = 0;
    for (r = 0; r < BufBytes; r++) pend_bytes[r] = 8'h00;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (r = 0; r < DirectedRows; r++) begin
      send_item(DirectedTable[r].midi, DirectedTable[r].ts, DirectedTable[r].typed,
                DirectedTable[r].n_typed, DirectedTable[r].beats);
    end
    hold_until_drained();

    while (random_items < RandomItems) begin
      if (random_items + CalmItems >= RandomItems) calm_tail = 1'b1;
      send_message();
      if ($urandom_range(0, 24) == 0) hold_until_drained();
    end
    s_axis_tvalid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
